// ===== rtl/gtbd_pkg.sv =====
// ----------------------------------------------------------------------------
// gtbd_pkg
// Shared types, widths and constants for the gray threshold block downsampler.
// ----------------------------------------------------------------------------
package gtbd_pkg;

    // Grid and line limits
    localparam int GRID     = 28;
    localparam int MAX_LINE = 2047;

    // Field and state widths
    localparam int COL_W      = 11;
    localparam int LINE_W     = $clog2(MAX_LINE + 1);
    localparam int IDX_W      = $clog2(GRID);
    localparam int BW_W       = 7;
    localparam int N_W        = 2 * BW_W;
    localparam int SUM_W      = 22;
    localparam int TRI_W      = 10;
    localparam int ROW_W      = 5;
    localparam int BYTE_W     = 8;
    localparam int INK_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Block arithmetic widths: 270n and 450n, 765n, 3n
    localparam int LVL_W  = N_W + 9;
    localparam int FULL_W = N_W + 10;
    localparam int D3_W   = N_W + 2;

    // Divider steps: quotient bits of level and ink
    localparam int DIV_STEPS = 17;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Register reset values
    localparam int FW_RESET = 640;
    localparam int BW_RESET = 22;
    localparam int BH_RESET = 17;

    // Threshold constants (pixel gray on channel sums, block level on n)
    localparam int GRAY_LO      = 60;
    localparam int GRAY_HI      = 140;
    localparam int GRAY_LO_SUM  = 3 * GRAY_LO;
    localparam int GRAY_HI_SUM  = 3 * GRAY_HI;
    localparam int BYTE_MAX     = 255;
    localparam int TRI_FULL     = 3 * BYTE_MAX;
    localparam int LVL_LO_MUL   = 3 * 90;
    localparam int LVL_HI_MUL   = 3 * 150;
    localparam int FULL_MUL     = TRI_FULL;
    localparam int D3_MUL       = 3;
    localparam int INK_ONE      = 65536;
    // floor(s/3) for s below 512 as (s * 683) >> 11
    localparam int GRAY_RECIP   = 683;
    localparam int GRAY_SHIFT   = 11;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_BLOCK_WIDTH  = 2'd1,
        CFG_BLOCK_HEIGHT = 2'd2
    } cfg_reg_t;

    // Input word
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              frame_start;
    } pixel_t;

    // Output word
    typedef struct packed {
        logic [BYTE_W-1:0] gray;
        logic              block_done;
        logic [ROW_W-1:0]  block_row;
        logic [ROW_W-1:0]  block_col;
        logic [BYTE_W-1:0] block_level;
        logic [INK_W-1:0]  ink;
    } result_t;

    // Classified pixel handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] gray;
        logic              done;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [SUM_W-1:0]  tsum;
        logic [N_W-1:0]    n;
    } entry_t;

endpackage

// ===== rtl/gtbd_front.sv =====
// ----------------------------------------------------------------------------
// gtbd_front
// Accepts pixels, computes clipped gray, tracks raster position and block
// sums, and pushes one classified word per pixel into the queue. Holds the
// configuration registers and rebuilds the block position after a write.
// ----------------------------------------------------------------------------
module gtbd_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr,
    input  logic [gtbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gtbd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           pix_valid,
    output logic                           pix_ready,
    input  gtbd_pkg::pixel_t               pix,
    output logic                           q_push,
    output gtbd_pkg::entry_t               q_data,
    input  logic                           q_full
);
    import gtbd_pkg::*;

    localparam int RC_STEPS = (COL_W > LINE_W) ? COL_W : LINE_W;
    localparam int RC_CNT_W = $clog2(RC_STEPS);
    localparam int PROD_W   = 2 * TRI_W;

    // Configuration
    logic [COL_W-1:0] fw_reg;
    logic [BW_W-1:0]  bw_reg;
    logic [BW_W-1:0]  bh_reg;
    logic [N_W-1:0]   n_reg;

    // Raster position and position within the grid
    logic [COL_W-1:0]  x_reg, x_next;
    logic [BW_W-1:0]   ix_reg, ix_next;
    logic [COL_W-1:0]  cx_reg, cx_next;
    logic [LINE_W-1:0] y_reg, y_next;
    logic [BW_W-1:0]   iy_reg, iy_next;
    logic [LINE_W-1:0] cy_reg, cy_next;

    logic [SUM_W-1:0] sums_reg [GRID];

    // Position rebuild after a configuration write
    logic                rc_busy_reg;
    logic [RC_CNT_W-1:0] rc_cnt_reg;
    logic [RC_STEPS-1:0] rc_qx_reg, rc_qy_reg;
    logic [BW_W-1:0]     rc_rx_reg, rc_ry_reg;

    logic [BW_W-1:0]     bw_eff, bh_eff;
    logic [RC_STEPS-1:0] xe, ye;
    logic [RC_CNT_W-1:0] bit_sel;
    logic [BW_W:0]       rx_try, ry_try;
    logic                rx_ge, ry_ge;
    logic [BW_W-1:0]     rx_new, ry_new;
    logic [RC_STEPS-1:0] qx_new, qy_new;
    logic                rc_last;

    logic              accept;
    logic              fs;
    logic [COL_W-1:0]  x_cur, cx_cur;
    logic [BW_W-1:0]   ix_cur, iy_cur;
    logic [LINE_W-1:0] y_cur, cy_cur;
    logic [TRI_W-1:0]  s;
    logic [PROD_W-1:0] gray_prod;
    logic [BYTE_W-1:0] gray;
    logic [TRI_W-1:0]  tri_val;
    logic              in_grid;
    logic [IDX_W-1:0]  idx;
    logic              blk_first, blk_last, done;
    logic [SUM_W-1:0]  base, sum_new;
    logic              col_wrap;
    logic [BW_W-1:0]   ix_inc, iy_inc;

    // Zero block size acts as one
    assign bw_eff = (bw_reg == '0) ? BW_W'(1) : bw_reg;
    assign bh_eff = (bh_reg == '0) ? BW_W'(1) : bh_reg;

    // One restoring division step for column and line, MSB first
    always_comb
    begin
        xe      = RC_STEPS'(x_reg);
        ye      = RC_STEPS'(y_reg);
        bit_sel = RC_CNT_W'(RC_STEPS - 1) - rc_cnt_reg;
        rx_try  = {rc_rx_reg, xe[bit_sel]};
        ry_try  = {rc_ry_reg, ye[bit_sel]};
        rx_ge   = rx_try >= {1'b0, bw_eff};
        ry_ge   = ry_try >= {1'b0, bh_eff};
        rx_new  = rx_ge ? BW_W'(rx_try - {1'b0, bw_eff}) : rx_try[BW_W-1:0];
        ry_new  = ry_ge ? BW_W'(ry_try - {1'b0, bh_eff}) : ry_try[BW_W-1:0];
        qx_new  = {rc_qx_reg[RC_STEPS-2:0], rx_ge};
        qy_new  = {rc_qy_reg[RC_STEPS-2:0], ry_ge};
        rc_last = rc_cnt_reg == RC_CNT_W'(RC_STEPS - 1);
    end

    // Hold pixels during a configuration write, while the position is rebuilt or the queue is full
    assign pix_ready = !rc_busy_reg && !q_full && !cfg_wr;
    assign accept    = pix_valid && pix_ready;
    assign q_push    = accept;

    // Classify the pixel and update the block sum
    always_comb
    begin
        fs     = pix.frame_start;
        x_cur  = fs ? '0 : x_reg;
        ix_cur = fs ? '0 : ix_reg;
        cx_cur = fs ? '0 : cx_reg;
        y_cur  = fs ? '0 : y_reg;
        iy_cur = fs ? '0 : iy_reg;
        cy_cur = fs ? '0 : cy_reg;

        s = TRI_W'(pix.red) + TRI_W'(pix.green) + TRI_W'(pix.blue);
        gray_prod = PROD_W'(s) * PROD_W'(GRAY_RECIP);
        if (s <= TRI_W'(GRAY_LO_SUM))
        begin
            gray    = '0;
            tri_val = '0;
        end
        else if (s >= TRI_W'(GRAY_HI_SUM))
        begin
            gray    = BYTE_W'(BYTE_MAX);
            tri_val = TRI_W'(TRI_FULL);
        end
        else
        begin
            gray    = gray_prod[GRAY_SHIFT +: BYTE_W];
            tri_val = s;
        end

        in_grid   = (cx_cur < COL_W'(GRID)) && (cy_cur < LINE_W'(GRID));
        idx       = cx_cur[IDX_W-1:0];
        blk_first = (ix_cur == '0) && (iy_cur == '0);
        base      = blk_first ? '0 : sums_reg[idx];
        sum_new   = base + SUM_W'(tri_val);
        blk_last  = (ix_cur == BW_W'(bw_eff - BW_W'(1)))
                 && (iy_cur == BW_W'(bh_eff - BW_W'(1)));
        done      = in_grid && blk_last;

        q_data.gray = gray;
        q_data.done = done;
        q_data.row  = done ? cy_cur[ROW_W-1:0] : '0;
        q_data.col  = done ? cx_cur[ROW_W-1:0] : '0;
        q_data.tsum = done ? sum_new : '0;
        q_data.n    = n_reg;
    end

    // Advance the raster position
    always_comb
    begin
        col_wrap = ({1'b0, x_cur} + (COL_W + 1)'(1)) >= {1'b0, fw_reg};
        ix_inc   = ix_cur + BW_W'(1);
        iy_inc   = iy_cur + BW_W'(1);
        x_next   = x_cur;
        ix_next  = ix_cur;
        cx_next  = cx_cur;
        y_next   = y_cur;
        iy_next  = iy_cur;
        cy_next  = cy_cur;
        if (col_wrap)
        begin
            x_next  = '0;
            ix_next = '0;
            cx_next = '0;
            if (y_cur >= LINE_W'(MAX_LINE))
            begin
                y_next = LINE_W'(MAX_LINE);
            end
            else
            begin
                y_next = y_cur + LINE_W'(1);
                if (iy_inc == bh_eff)
                begin
                    iy_next = '0;
                    cy_next = cy_cur + LINE_W'(1);
                end
                else
                begin
                    iy_next = iy_inc;
                end
            end
        end
        else
        begin
            x_next = x_cur + COL_W'(1);
            if (ix_inc == bw_eff)
            begin
                ix_next = '0;
                cx_next = cx_cur + COL_W'(1);
            end
            else
            begin
                ix_next = ix_inc;
            end
        end
    end

    // Registers: configuration, rebuild sequencer, position, sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg      <= COL_W'(FW_RESET);
            bw_reg      <= BW_W'(BW_RESET);
            bh_reg      <= BW_W'(BH_RESET);
            n_reg       <= N_W'(BW_RESET * BH_RESET);
            x_reg       <= '0;
            ix_reg      <= '0;
            cx_reg      <= '0;
            y_reg       <= '0;
            iy_reg      <= '0;
            cy_reg      <= '0;
            rc_busy_reg <= 1'b0;
            rc_cnt_reg  <= '0;
            rc_qx_reg   <= '0;
            rc_qy_reg   <= '0;
            rc_rx_reg   <= '0;
            rc_ry_reg   <= '0;
            for (int i = 0; i < GRID; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  fw_reg <= cfg_data;
                CFG_BLOCK_WIDTH:  bw_reg <= cfg_data[BW_W-1:0];
                CFG_BLOCK_HEIGHT: bh_reg <= cfg_data[BW_W-1:0];
                default:          ;
            endcase
            rc_busy_reg <= 1'b1;
            rc_cnt_reg  <= '0;
            rc_qx_reg   <= '0;
            rc_qy_reg   <= '0;
            rc_rx_reg   <= '0;
            rc_ry_reg   <= '0;
        end
        else if (rc_busy_reg)
        begin
            rc_qx_reg <= qx_new;
            rc_qy_reg <= qy_new;
            rc_rx_reg <= rx_new;
            rc_ry_reg <= ry_new;
            if (rc_last)
            begin
                rc_busy_reg <= 1'b0;
                cx_reg      <= COL_W'(qx_new);
                ix_reg      <= rx_new;
                cy_reg      <= LINE_W'(qy_new);
                iy_reg      <= ry_new;
                n_reg       <= N_W'(bw_eff) * N_W'(bh_eff);
            end
            else
            begin
                rc_cnt_reg <= rc_cnt_reg + RC_CNT_W'(1);
            end
        end
        else if (accept)
        begin
            x_reg  <= x_next;
            ix_reg <= ix_next;
            cx_reg <= cx_next;
            y_reg  <= y_next;
            iy_reg <= iy_next;
            cy_reg <= cy_next;
            // Update the current block's sum; clear the rest on a frame start
            for (int i = 0; i < GRID; i++)
            begin
                if (in_grid && (idx == IDX_W'(i)))
                begin
                    sums_reg[i] <= sum_new;
                end
                else if (fs)
                begin
                    sums_reg[i] <= '0;
                end
            end
        end
    end

endmodule

// ===== rtl/gtbd_fifo.sv =====
// ----------------------------------------------------------------------------
// gtbd_fifo
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module gtbd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  gtbd_pkg::entry_t push_data,
    output logic             full,
    input  logic             pop,
    output gtbd_pkg::entry_t pop_data,
    output logic             empty
);
    import gtbd_pkg::*;

    entry_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]   count_reg;

    assign full     = count_reg == (Q_AW + 1)'(Q_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + Q_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (Q_AW + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (Q_AW + 1)'(1);
            end
        end
    end

endmodule

// ===== rtl/gtbd_div.sv =====
// ----------------------------------------------------------------------------
// gtbd_div
// Restoring divider, one quotient bit a cycle. Computes the block level
// floor(T / 3n) and the rounded ink ((765n - T) * 2^17 + 765n) / (2 * 765n)
// side by side.
// ----------------------------------------------------------------------------
module gtbd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gtbd_pkg::SUM_W-1:0]  tsum,
    input  logic [gtbd_pkg::D3_W-1:0]   d3,
    input  logic [gtbd_pkg::FULL_W-1:0] full,
    output logic                        done,
    output logic [gtbd_pkg::BYTE_W-1:0] level,
    output logic [gtbd_pkg::INK_W-1:0]  ink
);
    import gtbd_pkg::*;

    localparam int IREM_W = FULL_W + 1;
    localparam int CNT_W  = $clog2(DIV_STEPS);

    logic                 busy_reg, done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [D3_W-1:0]      d3_reg, lrem_reg, lrem_new;
    logic [DIV_STEPS-1:0] lsh_reg, lq_reg;
    logic [IREM_W-1:0]    d2_reg, irem_reg, irem_new, irem_init;
    logic [DIV_STEPS-1:0] ish_reg, iq_reg;
    logic [D3_W:0]        ltry;
    logic [IREM_W:0]      itry;
    logic                 lge, ige;

    // One step of each division
    always_comb
    begin
        ltry      = {lrem_reg, lsh_reg[DIV_STEPS-1]};
        lge       = ltry >= {1'b0, d3_reg};
        lrem_new  = lge ? D3_W'(ltry - {1'b0, d3_reg}) : ltry[D3_W-1:0];
        itry      = {irem_reg, ish_reg[DIV_STEPS-1]};
        ige       = itry >= {1'b0, d2_reg};
        irem_new  = ige ? IREM_W'(itry - {1'b0, d2_reg}) : itry[IREM_W-1:0];
        irem_init = IREM_W'(full - FULL_W'(tsum)) + IREM_W'(full >> DIV_STEPS);
    end

    assign done  = done_reg;
    assign level = lq_reg[BYTE_W-1:0];
    assign ink   = INK_W'(iq_reg);

    // Load on start, then shift one bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d3_reg   <= d3;
            lrem_reg <= D3_W'(tsum >> DIV_STEPS);
            lsh_reg  <= tsum[DIV_STEPS-1:0];
            lq_reg   <= '0;
            d2_reg   <= {full, 1'b0};
            irem_reg <= irem_init;
            ish_reg  <= full[DIV_STEPS-1:0];
            iq_reg   <= '0;
        end
        else if (busy_reg)
        begin
            lrem_reg <= lrem_new;
            lsh_reg  <= {lsh_reg[DIV_STEPS-2:0], 1'b0};
            lq_reg   <= {lq_reg[DIV_STEPS-2:0], lge};
            irem_reg <= irem_new;
            ish_reg  <= {ish_reg[DIV_STEPS-2:0], 1'b0};
            iq_reg   <= {iq_reg[DIV_STEPS-2:0], ige};
        end
    end

endmodule

// ===== rtl/gtbd_back.sv =====
// ----------------------------------------------------------------------------
// gtbd_back
// Pops classified words, finishes completed blocks (thresholds, level and
// ink through the divider) and holds each result in an output register.
// ----------------------------------------------------------------------------
module gtbd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    output logic              q_pop,
    input  gtbd_pkg::entry_t  q_data,
    output logic              res_valid,
    input  logic              res_ready,
    output gtbd_pkg::result_t res
);
    import gtbd_pkg::*;

    typedef enum logic [4:0] {
        BK_IDLE = 5'b00001,
        BK_PREP = 5'b00010,
        BK_CALC = 5'b00100,
        BK_DIV  = 5'b01000,
        BK_FIN  = 5'b10000
    } back_state_t;

    back_state_t       state_reg, state_next;
    entry_t            work_reg, work_next;
    logic [LVL_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [FULL_W-1:0] full_reg, full_next;
    logic [D3_W-1:0]   d3_reg, d3_next;
    logic [BYTE_W-1:0] level_reg, level_next;
    logic [INK_W-1:0]  ink_reg, ink_next;
    logic              res_valid_reg, res_valid_next;
    result_t           res_reg, res_next;

    logic              out_free;
    logic [FULL_W-1:0] t_ext;
    logic              div_start, div_done;
    logic [BYTE_W-1:0] div_level;
    logic [INK_W-1:0]  div_ink;

    gtbd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .tsum  (work_reg.tsum),
        .d3    (d3_reg),
        .full  (full_reg),
        .done  (div_done),
        .level (div_level),
        .ink   (div_ink)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Sequence one word at a time through the block arithmetic
    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        full_next      = full_reg;
        d3_next        = d3_reg;
        level_next     = level_reg;
        ink_next       = ink_reg;
        res_next       = res_reg;
        out_free       = !res_valid_reg || res_ready;
        res_valid_next = res_valid_reg && !res_ready;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        t_ext          = FULL_W'(work_reg.tsum);

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop = 1'b1;
                    if (!q_data.done)
                    begin
                        res_next.gray        = q_data.gray;
                        res_next.block_done  = 1'b0;
                        res_next.block_row   = '0;
                        res_next.block_col   = '0;
                        res_next.block_level = '0;
                        res_next.ink         = '0;
                        res_valid_next       = 1'b1;
                    end
                    else
                    begin
                        work_next  = q_data;
                        state_next = BK_PREP;
                    end
                end
            end
            BK_PREP:
            begin
                lo_next    = LVL_W'(work_reg.n) * LVL_W'(LVL_LO_MUL);
                hi_next    = LVL_W'(work_reg.n) * LVL_W'(LVL_HI_MUL);
                full_next  = FULL_W'(work_reg.n) * FULL_W'(FULL_MUL);
                d3_next    = D3_W'(work_reg.n) * D3_W'(D3_MUL);
                state_next = BK_CALC;
            end
            BK_CALC:
            begin
                if (t_ext <= FULL_W'(lo_reg))
                begin
                    level_next = '0;
                    ink_next   = INK_W'(INK_ONE);
                    state_next = BK_FIN;
                end
                else if (t_ext >= FULL_W'(hi_reg))
                begin
                    level_next = BYTE_W'(BYTE_MAX);
                    ink_next   = '0;
                    state_next = BK_FIN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    level_next = div_level;
                    ink_next   = div_ink;
                    state_next = BK_FIN;
                end
            end
            BK_FIN:
            begin
                if (out_free)
                begin
                    res_next.gray        = work_reg.gray;
                    res_next.block_done  = 1'b1;
                    res_next.block_row   = work_reg.row;
                    res_next.block_col   = work_reg.col;
                    res_next.block_level = level_reg;
                    res_next.ink         = ink_reg;
                    res_valid_next       = 1'b1;
                    state_next           = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        full_reg  <= full_next;
        d3_reg    <= d3_next;
        level_reg <= level_next;
        ink_reg   <= ink_next;
        res_reg   <= res_next;
    end

endmodule

// ===== rtl/gray_threshold_block_downsample_top.sv =====
// ----------------------------------------------------------------------------
// gray_threshold_block_downsample_top
// Gray threshold and 28 by 28 block average downsampler for a raster pixel
// stream.
//
//   channel  signals                           word
//   pix      pix_valid / pix_ready / pix       red, green, blue, frame_start
//   res      res_valid / res_ready / res       gray, block fields, ink
//   cfg      cfg_valid / cfg_ready / index     frame_width, block size
//
// Pixels that complete no block pass back to back while the output is free,
// each result registered through the queue and then the output register. A
// block-completing pixel goes through setup and threshold compare in the back
// end and, unless its mean clips, a 17-step restoring divider for level and
// ink; a four-word queue lets the front keep taking pixels meanwhile. A
// configuration write holds pix_ready low during and after the write while
// the block position is rebuilt by bit-serial division. Reset clears all
// counters and block sums at once; no clearing pass.
// ----------------------------------------------------------------------------
module gray_threshold_block_downsample_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pix_valid,
    output logic                           pix_ready,
    input  gtbd_pkg::pixel_t               pix,
    output logic                           res_valid,
    input  logic                           res_ready,
    output gtbd_pkg::result_t              res,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gtbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gtbd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gtbd_pkg::*;

    entry_t push_data, pop_data;
    logic   push, pop, q_full, q_empty;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    gtbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .q_push    (push),
        .q_data    (push_data),
        .q_full    (q_full)
    );

    gtbd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    gtbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (pop),
        .q_data    (pop_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

// ===== rtl/gtbd_checker.sv =====
// ----------------------------------------------------------------------------
// gtbd_checker
// Port-level checks on the downsampler top, attached by bind.
// ----------------------------------------------------------------------------
module gtbd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              pix_ready,
    input logic              res_valid,
    input logic              res_ready,
    input gtbd_pkg::result_t res,
    input logic              cfg_valid,
    input logic              cfg_ready
);
    import gtbd_pkg::*;

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // Block fields stay zero on words that complete no block
    a_no_block_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.block_done |->
            res.block_row == '0 && res.block_col == '0
            && res.block_level == '0 && res.ink == '0)
        else $error("block fields set without a completed block");

    // Clipped-low block carries full ink
    a_low_ink: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.block_done && res.block_level == '0 |->
            res.ink == INK_W'(INK_ONE))
        else $error("zero level without full ink");

    // Clipped-high block carries no ink
    a_high_ink: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.block_done && res.block_level == BYTE_W'(BYTE_MAX) |->
            res.ink == '0)
        else $error("full level with nonzero ink");

    // Drop pixel ready while the position is rebuilt after a write
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !pix_ready)
        else $error("pixel taken right after a configuration write");

endmodule

bind gray_threshold_block_downsample_top gtbd_checker u_checker (.*);

// ===== tb/tb_gray_threshold_block_downsample_top.sv =====
// ----------------------------------------------------------------------------
// tb_gray_threshold_block_downsample_top
// Self-checking bench for the gray threshold block downsampler. Drives pixel
// words in raster order under several block geometries, predicts each gray
// byte and each completed block (level and ink), and checks every result word
// in order. The bench walks through phases of sender gaps, receiver stalls,
// a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_gray_threshold_block_downsample_top;

    timeunit 1ns;
    timeprecision 1ps;

    import gtbd_pkg::*;

    localparam int LONG_STALL    = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 40;

    typedef enum int {NO_GAPS, SENDER_GAPS, RECEIVER_STALLS, BOTH_GAPS} idle_mode_t;

    // Predicts the gray byte and block results of each pixel word and holds
    // the results still awaited from the block.
    class block_average_board;
        logic [COL_W-1:0]  frame_width;
        logic [BW_W-1:0]   block_width;
        logic [BW_W-1:0]   block_height;
        logic [COL_W-1:0]  column_pos;
        logic [LINE_W-1:0] line_pos;
        logic [SUM_W-1:0]  row_sums [GRID];
        result_t           awaited [$];
        int                errors;

        function new();
            frame_width  = COL_W'(FW_RESET);
            block_width  = BW_W'(BW_RESET);
            block_height = BW_W'(BH_RESET);
            column_pos   = '0;
            line_pos     = '0;
            foreach (row_sums[i])
                row_sums[i] = '0;
            errors = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_FRAME_WIDTH:  frame_width  = value;
                CFG_BLOCK_WIDTH:  block_width  = value[BW_W-1:0];
                CFG_BLOCK_HEIGHT: block_height = value[BW_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void take_pixel(pixel_t p);
            int unsigned       s;
            int unsigned       t;
            int unsigned       bw_eff;
            int unsigned       bh_eff;
            int unsigned       x;
            int unsigned       y;
            int unsigned       cx;
            int unsigned       cy;
            longint unsigned   n;
            longint unsigned   tri_sum;
            longint unsigned   full;
            result_t           r;

            s = int'(p.red) + int'(p.green) + int'(p.blue);
            r = '0;

            // Clear counters and sums ahead of a frame's first pixel
            if (p.frame_start) begin
                column_pos = '0;
                line_pos   = '0;
                foreach (row_sums[i])
                    row_sums[i] = '0;
            end

            // Clip the pixel gray; t is its exact triple contribution
            if (s <= GRAY_LO_SUM) begin
                r.gray = '0;
                t      = 0;
            end else if (s >= GRAY_HI_SUM) begin
                r.gray = BYTE_W'(BYTE_MAX);
                t      = TRI_FULL;
            end else begin
                r.gray = BYTE_W'(s / 3);
                t      = s;
            end

            bw_eff = (block_width == '0) ? 32'd1 : 32'(block_width);
            bh_eff = (block_height == '0) ? 32'd1 : 32'(block_height);
            x  = 32'(column_pos);
            y  = 32'(line_pos);
            cx = x / bw_eff;
            cy = y / bh_eff;

            // Accumulate inside the grid; load on a block's first pixel
            if (cx < GRID && cy < GRID) begin
                if (x % bw_eff == 0 && y % bh_eff == 0)
                    row_sums[cx] = SUM_W'(t);
                else
                    row_sums[cx] = SUM_W'(row_sums[cx] + t);

                if (x % bw_eff == bw_eff - 1 && y % bh_eff == bh_eff - 1) begin
                    n       = 64'(bw_eff) * 64'(bh_eff);
                    tri_sum = 64'(row_sums[cx]);
                    r.block_done = 1'b1;
                    r.block_row  = cy[ROW_W-1:0];
                    r.block_col  = cx[ROW_W-1:0];
                    if (tri_sum <= LVL_LO_MUL * n) begin
                        r.block_level = '0;
                        r.ink         = INK_W'(INK_ONE);
                    end else if (tri_sum >= LVL_HI_MUL * n) begin
                        r.block_level = BYTE_W'(BYTE_MAX);
                        r.ink         = '0;
                    end else begin
                        // Ink from the exact mean, round half up
                        full          = FULL_MUL * n;
                        r.block_level = BYTE_W'(tri_sum / (D3_MUL * n));
                        r.ink = INK_W'((2 * (full - tri_sum) * INK_ONE + full)
                                       / (2 * full));
                    end
                end
            end

            // Advance the raster position; saturate the line count
            if (x + 1 >= frame_width) begin
                column_pos = '0;
                line_pos   = LINE_W'((y >= MAX_LINE) ? MAX_LINE : y + 1);
            end else begin
                column_pos = COL_W'(x + 1);
            end

            awaited.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: result word with nothing awaited, expected none, got %h",
                             $time, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            check_field("gray", 32'(want.gray), 32'(got.gray));
            check_field("block_done", 32'(want.block_done), 32'(got.block_done));
            check_field("block_row", 32'(want.block_row), 32'(got.block_row));
            check_field("block_col", 32'(want.block_col), 32'(got.block_col));
            check_field("block_level", 32'(want.block_level), 32'(got.block_level));
            check_field("ink", 32'(want.ink), 32'(got.ink));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  pix_valid;
    logic                  pix_ready;
    pixel_t                pix;
    logic                  res_valid;
    logic                  res_ready;
    result_t               res;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    block_average_board board;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    bit                 stall_request;

    gray_threshold_block_downsample_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #10ms;
        $display("Mismatches found");
        $finish;
    end

    // Note accepted pixel words first, then check accepted result words
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (pix_valid && pix_ready)
                board.take_pixel(pix);
            if (res_valid && res_ready)
                board.check_result(res);
        end
    end

    // Drive res_ready: random stalls, or a long hold-off on request
    initial
    begin
        res_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (stall_request) begin
                stall_request = 1'b0;
                res_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic pixel_t rgb(int r, int g, int b, bit fs);
        pixel_t p;
        p.red         = BYTE_W'(r);
        p.green       = BYTE_W'(g);
        p.blue        = BYTE_W'(b);
        p.frame_start = fs;
        return p;
    endfunction

    function automatic logic [BYTE_W-1:0] near_tone(int tone);
        int v;
        v = tone + int'($urandom_range(8)) - 4;
        if (v < 0)
            v = 0;
        else if (v > BYTE_MAX)
            v = BYTE_MAX;
        return v[BYTE_W-1:0];
    endfunction

    // Mostly pixels near a local tone, some fully random
    function automatic pixel_t make_pixel(int tone, bit fs);
        pixel_t p;
        if ($urandom_range(99) < 25) begin
            p.red   = 8'($urandom);
            p.green = 8'($urandom);
            p.blue  = 8'($urandom);
        end else begin
            p.red   = near_tone(tone);
            p.green = near_tone(tone);
            p.blue  = near_tone(tone);
        end
        p.frame_start = fs;
        return p;
    endfunction

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            NO_GAPS:         begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            SENDER_GAPS:     begin send_idle_pct = 59; recv_stall_pct = 0;  end
            RECEIVER_STALLS: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default:         begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        endcase
    endtask

    // Offer one pixel word, after optional idle cycles; hold until accepted
    task automatic send_pixel(pixel_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        do @(posedge clk); while (!pix_ready);
    endtask

    task automatic write_register(cfg_reg_t idx, int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        board.set_register(idx, value[CFG_DATA_W-1:0]);
    endtask

    // Drain all results, then write all three registers
    task automatic apply_setting(int unsigned fw, int unsigned bw, int unsigned bh);
        do @(posedge clk); while (board.pending() != 0);
        write_register(CFG_FRAME_WIDTH, fw);
        write_register(CFG_BLOCK_WIDTH, bw);
        write_register(CFG_BLOCK_HEIGHT, bh);
        cfg_valid <= 1'b0;
    endtask

    // Stream random pixels; optionally request a long output hold-off or
    // pause until drained at a given pixel
    task automatic run_frames(int count, bit open_frame, int hold_at, int pause_at);
        int tone;
        bit fs;
        tone = 128;
        for (int i = 0; i < count; i++) begin
            if (i % 8 == 0)
                tone = ($urandom_range(99) < 60) ? int'($urandom_range(40, 170))
                                                 : int'($urandom_range(255));
            if (i == hold_at)
                stall_request = 1'b1;
            if (i == pause_at) begin
                pix_valid <= 1'b0;
                do @(posedge clk); while (board.pending() != 0);
            end
            fs = (i == 0 && open_frame) || ($urandom_range(199) == 0);
            send_pixel(make_pixel(tone, fs));
        end
        pix_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        pix_valid      = 1'b0;
        pix            = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_FRAME_WIDTH;
        cfg_data       = '0;
        stall_request  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        board = new();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Gray thresholds and channel extremes at reset geometry
        set_idling(NO_GAPS);
        send_pixel(rgb(0, 0, 0, 1));
        send_pixel(rgb(60, 60, 60, 0));
        send_pixel(rgb(61, 60, 60, 0));
        send_pixel(rgb(140, 140, 139, 0));
        send_pixel(rgb(140, 140, 140, 0));
        send_pixel(rgb(255, 255, 255, 0));
        send_pixel(rgb(8'hAA, 8'h55, 8'hAA, 0));
        send_pixel(rgb(8'h55, 8'hAA, 8'h55, 1));
        pix_valid <= 1'b0;

        // One-pixel lines, zero block size: every pixel closes a block
        apply_setting(1, 0, 0);
        send_pixel(rgb(0, 0, 0, 1));
        send_pixel(rgb(90, 90, 90, 0));
        send_pixel(rgb(91, 90, 90, 0));
        send_pixel(rgb(140, 140, 139, 0));
        send_pixel(rgb(255, 255, 255, 0));
        pix_valid <= 1'b0;

        // Zero frame width wraps every pixel; frame start restarts the grid
        apply_setting(0, 1, 1);
        send_pixel(rgb(255, 0, 255, 0));
        send_pixel(rgb(100, 100, 100, 1));
        pix_valid <= 1'b0;

        // Block mean exactly at the upper clip, then just below it
        apply_setting(3, 3, 1);
        send_pixel(rgb(255, 255, 255, 1));
        send_pixel(rgb(100, 100, 100, 0));
        send_pixel(rgb(95, 95, 95, 0));
        send_pixel(rgb(255, 255, 255, 0));
        send_pixel(rgb(100, 100, 100, 0));
        send_pixel(rgb(95, 95, 94, 0));
        pix_valid <= 1'b0;

        // Random frames over several geometries
        apply_setting(28, 1, 1);
        set_idling(NO_GAPS);
        run_frames(200, 1, -1, -1);

        apply_setting(56, 2, 2);
        set_idling(SENDER_GAPS);
        run_frames(200, 1, 100, -1);

        apply_setting(40, 1, 3);
        set_idling(RECEIVER_STALLS);
        run_frames(120, 1, -1, -1);

        // Last block column runs past the frame edge
        apply_setting(29, 3, 1);
        set_idling(BOTH_GAPS);
        run_frames(120, 1, -1, 70);

        apply_setting(2047, 73, 73);
        set_idling(SENDER_GAPS);
        run_frames(40, 1, -1, -1);

        apply_setting(2047, 127, 0);
        set_idling(NO_GAPS);
        run_frames(20, 1, -1, -1);

        // Change geometry mid-frame and carry on without a frame start
        apply_setting(60, 2, 1);
        set_idling(RECEIVER_STALLS);
        run_frames(120, 0, -1, -1);

        // One-pixel lines run past the bottom of the grid
        apply_setting(1, 1, 1);
        set_idling(NO_GAPS);
        run_frames(60, 1, -1, -1);

        apply_setting(100, 3, 2);
        set_idling(BOTH_GAPS);
        run_frames(150, 1, 60, -1);

        apply_setting(28, 1, 2);
        set_idling(NO_GAPS);
        run_frames(100, 1, -1, -1);

        // Drain, settle, report
        do @(posedge clk); while (board.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
